@@ rtl/core/pil_pkg.sv @@
// Package for the positional insert/delete list unit.
// Holds capacity constants, operation and status codes and the transaction structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pil_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DUMP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] item_value;
    logic [4:0]         position;
    logic               at_tail;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] entry_value;
    logic [3:0]         entry_index;
    logic [4:0]         list_size;
    logic               last_result;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;       // accepted request transaction
    logic dump_step;  // emit next dumped entry
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can load this cycle
    logic dump_go;    // current request is a non-empty dump
    logic dump_last;  // dump index points at final entry
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/positional_insert_delete_list_unit.sv @@
// Channel  Handshake              Payload
// req      req_valid/req_ready    pil_pkg::req_t  (kind, item_value, position, at_tail)
// rsp      rsp_valid/rsp_ready    pil_pkg::rsp_t  (status, entry_value, entry_index,
//                                                  list_size, last_result)
// Insert, delete and unused kinds shift the whole row of cells at once and
// register the result at the accepting edge.
// A dump of N entries emits one entry per cycle from a single read mux while
// rsp_ready stays high; the request side is held off until the last entry.
// A stalled output register holds off new requests; synchronous active-high reset
// empties the list.
// Top level of the positional insert/delete list unit. Depends on pil_pkg,
// pil_ctrl and pil_dpath.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_list_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire pil_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output pil_pkg::rsp_t      rsp
);

  pil_pkg::cmd_t  cmd;
  pil_pkg::stat_t stat;

  pil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pil_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

@@ rtl/core/pil_ctrl.sv @@
// Controller FSM for the positional insert/delete list unit.
// Sequences single-result operations and dumps that emit one result per entry. Depends on pil_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pil_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire pil_pkg::stat_t stat,
  output pil_pkg::cmd_t      cmd
);

  pil_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pil_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pil_pkg::S_IDLE: begin
        if (req_valid && req_ready && stat.dump_go) begin
          state_next = pil_pkg::S_DUMP;
        end
      end
      pil_pkg::S_DUMP: begin
        if (stat.out_free && stat.dump_last) begin
          state_next = pil_pkg::S_IDLE;
        end
      end
      default: state_next = pil_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = 1'b0;
    cmd.exec      = 1'b0;
    cmd.dump_step = 1'b0;
    unique case (state)
      pil_pkg::S_IDLE: begin
        req_ready = stat.out_free;
        cmd.exec  = req_valid && stat.out_free;
      end
      pil_pkg::S_DUMP: begin
        cmd.dump_step = stat.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/pil_dpath.sv @@
// Datapath for the positional insert/delete list unit: entry cells, count,
// dump index and the output register. Depends on pil_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pil_dpath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pil_pkg::req_t req,
  input  wire pil_pkg::cmd_t cmd,
  output pil_pkg::stat_t     stat,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output pil_pkg::rsp_t      rsp
);

  localparam int CAP   = pil_pkg::CAPACITY;
  localparam int IDX_W = pil_pkg::IDX_W;
  localparam int CNT_W = pil_pkg::CNT_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(pil_pkg::CAPACITY);
  localparam logic [CNT_W-1:0] DMAX  =
      CNT_W'((pil_pkg::CAPACITY < pil_pkg::MAX_RESULTS) ?
             pil_pkg::CAPACITY : pil_pkg::MAX_RESULTS);

  logic signed [31:0] entries [CAP];
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;

  logic [CNT_W-1:0]   ins_pos, del_pos, dump_n;
  logic               ins_ok, del_ok;
  pil_pkg::status_t   op_status;
  logic [CNT_W-1:0]   count_next;

  assign ins_pos = req.at_tail ? count : CNT_W'(req.position);
  assign del_pos = req.at_tail ? (count - CNT_W'(1)) : CNT_W'(req.position);
  assign dump_n  = (count > DMAX) ? DMAX : count;

  assign stat.out_free  = !rsp_valid || rsp_ready;
  assign stat.dump_go   = (req.kind == pil_pkg::KIND_DUMP) && (count != '0);
  assign stat.dump_last = ({1'b0, idx} + CNT_W'(1)) == dump_n;

  // decode of the request against the current count
  always_comb begin
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    op_status  = pil_pkg::ST_OK;
    count_next = count;
    unique case (req.kind)
      pil_pkg::KIND_INSERT: begin
        if (ins_pos > count) begin
          op_status = pil_pkg::ST_BAD_INDEX;
        end else if (count >= CAP_C) begin
          op_status = pil_pkg::ST_FULL;
        end else begin
          ins_ok     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      pil_pkg::KIND_DELETE: begin
        if (count == '0) begin
          op_status = pil_pkg::ST_EMPTY;
        end else if (del_pos >= count) begin
          op_status = pil_pkg::ST_BAD_INDEX;
        end else begin
          del_ok     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      pil_pkg::KIND_DUMP: begin
        if (count == '0) begin
          op_status = pil_pkg::ST_EMPTY;
        end
      end
      default: begin
        op_status = pil_pkg::ST_OK;
      end
    endcase
  end

  // every cell takes its own value, the inserted item, its lower or its upper neighbor
  always_ff @(posedge clk) begin
    if (cmd.exec && ins_ok) begin
      for (int j = 0; j < CAP; j++) begin
        if (CNT_W'(j) == ins_pos) begin
          entries[j] <= req.item_value;
        end else if (j > 0 && CNT_W'(j) > ins_pos) begin
          entries[j] <= entries[(j > 0) ? j - 1 : 0];
        end
      end
    end else if (cmd.exec && del_ok) begin
      for (int j = 0; j < CAP - 1; j++) begin
        if (CNT_W'(j) >= del_pos) begin
          entries[j] <= entries[j + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        count <= count_next;
        idx   <= '0;
        if (!stat.dump_go) begin
          rsp_valid <= 1'b1;
        end else if (rsp_ready) begin
          rsp_valid <= 1'b0;
        end
      end else if (cmd.dump_step) begin
        idx       <= idx + IDX_W'(1);
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !stat.dump_go) begin
      rsp.status      <= op_status;
      rsp.entry_value <= '0;
      rsp.entry_index <= '0;
      rsp.list_size   <= 5'(count_next);
      rsp.last_result <= 1'b1;
    end else if (cmd.dump_step) begin
      rsp.status      <= pil_pkg::ST_OK;
      rsp.entry_value <= entries[idx];
      rsp.entry_index <= 4'(idx);
      rsp.list_size   <= 5'(count);
      rsp.last_result <= stat.dump_last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pil_chk.sv @@
// Port-level checker for the positional insert/delete list unit, bound to the
// top level. Depends on pil_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pil_chk (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire pil_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire pil_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_size_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.list_size <= 5'(pil_pkg::CAPACITY))
    else $error("list size above capacity");

  a_full_size: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == pil_pkg::ST_FULL
      |-> rsp.list_size == 5'(pil_pkg::CAPACITY) && rsp.last_result)
    else $error("full status without a full list");

  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == pil_pkg::ST_EMPTY
      |-> rsp.list_size == '0 && rsp.entry_value == '0 && rsp.last_result)
    else $error("empty status with bad fields");

  a_mid_dump_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last_result |-> rsp.status == pil_pkg::ST_OK && !req_ready)
    else $error("non-final result not an ok dump entry");

endmodule

bind positional_insert_delete_list_unit pil_chk u_pil_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
